### sv/lzw_cached_code_decoder_unit_defines.svh
// Assertion macros shared by the cached-code LZW decoder RTL.
`ifndef LZW_CACHED_CODE_DECODER_UNIT_DEFINES_SVH
`define LZW_CACHED_CODE_DECODER_UNIT_DEFINES_SVH

// Checked on every clock edge outside reset.
`define LZWCCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define LZWCCD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/lzwccd_pkg.sv
// Shared constants, state encoding and controller/datapath bundles.
`timescale 1ns / 1ps
`default_nettype none
package lzwccd_pkg;

  localparam int unsigned BASE_ENTRIES = 256;
  localparam int unsigned CODE_W       = 12;
  localparam int unsigned LEN_W        = 7;
  localparam int unsigned BYTE_W       = 8;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SLOT,
    ST_SLOT_CAP,
    ST_CHECK,
    ST_PREV_CAP,
    ST_FIRST_BYTE,
    ST_FIRST_CAP,
    ST_COPY,
    ST_COPY_END,
    ST_ADD,
    ST_SRCH,
    ST_ROT,
    ST_ROT_FIN,
    ST_CUR_CAP,
    ST_OUT_RD,
    ST_OUT,
    ST_REJECT
  } state_t;

  typedef struct packed {
    logic accept;
    logic slot;
    logic slot_cap;
    logic ent_rd_prev;
    logic prev_cap;
    logic ent_rd_cur;
    logic first_rd;
    logic first_cap;
    logic copy;
    logic add;
    logic touch_cur;
    logic srch;
    logic rot;
    logic rot_fin;
    logic cur_cap;
    logic out_rd;
    logic out_load;
    logic rej_load;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic from_cache;
    logic slot_bad;
    logic slot_wpos;
    logic cur_bad;
    logic do_add;
    logic add_bad;
    logic copy_last;
    logic hit;
    logic miss;
    logic rot_end;
    logic out_free;
    logic out_last;
  } sts_t;

endpackage
`default_nettype wire

### sv/lzwccd_in_if.sv
// Code request channel: valid/ready with the code fields.
`timescale 1ns / 1ps
`default_nettype none
interface lzwccd_in_if;
  logic        valid;
  logic        ready;
  logic        first_of_message;
  logic        from_cache;
  logic [11:0] code;

  modport source (output valid, output first_of_message, output from_cache, output code,
                  input ready);
  modport sink (input valid, input first_of_message, input from_cache, input code,
                output ready);
endinterface
`default_nettype wire

### sv/lzwccd_out_if.sv
// Decoded byte channel: valid/ready with byte, last and error.
`timescale 1ns / 1ps
`default_nettype none
interface lzwccd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic       error;

  modport source (output valid, output out_byte, output last, output error, input ready);
  modport sink (input valid, input out_byte, input last, input error, output ready);
endinterface
`default_nettype wire

### sv/lzwccd_ctrl.sv
// Controller state machine sequencing one code request at a time.
`timescale 1ns / 1ps
`default_nettype none
module lzwccd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  lzwccd_pkg::sts_t   sts,
  output lzwccd_pkg::cmd_t   cmd
);
  import lzwccd_pkg::*;

  state_t state, state_next;
  logic   add_phase, add_phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      add_phase <= 1'b0;
    end else begin
      state     <= state_next;
      add_phase <= add_phase_next;
    end
  end

  always_comb begin
    cmd            = '0;
    state_next     = state;
    add_phase_next = add_phase;
    in_ready       = (state == ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = sts.from_cache ? ST_SLOT : ST_CHECK;
        end
      end
      ST_SLOT: begin
        cmd.slot = 1'b1;
        if (sts.slot_bad) state_next = ST_REJECT;
        else if (sts.slot_wpos) state_next = ST_CHECK;
        else state_next = ST_SLOT_CAP;
      end
      ST_SLOT_CAP: begin
        cmd.slot_cap = 1'b1;
        state_next   = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.cur_bad) begin
          state_next = ST_REJECT;
        end else if (sts.do_add) begin
          cmd.ent_rd_prev = 1'b1;
          add_phase_next  = 1'b1;
          state_next      = ST_PREV_CAP;
        end else begin
          cmd.touch_cur  = 1'b1;
          add_phase_next = 1'b0;
          state_next     = ST_SRCH;
        end
      end
      ST_PREV_CAP: begin
        cmd.prev_cap = 1'b1;
        if (sts.add_bad) begin
          state_next = ST_REJECT;
        end else begin
          cmd.ent_rd_cur = 1'b1;
          state_next     = ST_FIRST_BYTE;
        end
      end
      ST_FIRST_BYTE: begin
        cmd.first_rd = 1'b1;
        state_next   = ST_FIRST_CAP;
      end
      ST_FIRST_CAP: begin
        cmd.first_cap = 1'b1;
        state_next    = ST_COPY;
      end
      ST_COPY: begin
        cmd.copy = 1'b1;
        if (sts.copy_last) state_next = ST_COPY_END;
      end
      ST_COPY_END: begin
        state_next = ST_ADD;
      end
      ST_ADD: begin
        cmd.add    = 1'b1;
        state_next = ST_SRCH;
      end
      ST_SRCH, ST_ROT_FIN: begin
        if (state == ST_ROT_FIN) cmd.rot_fin = 1'b1;
        else cmd.srch = 1'b1;
        if (state == ST_SRCH && sts.hit) begin
          state_next = ST_ROT;
        end else if (state == ST_ROT_FIN || sts.miss) begin
          // ring update done: touch the current code, or fetch its entry
          if (add_phase) begin
            cmd.touch_cur  = 1'b1;
            add_phase_next = 1'b0;
            state_next     = ST_SRCH;
          end else begin
            cmd.ent_rd_cur = 1'b1;
            state_next     = ST_CUR_CAP;
          end
        end
      end
      ST_ROT: begin
        cmd.rot = 1'b1;
        if (sts.rot_end) state_next = ST_ROT_FIN;
      end
      ST_CUR_CAP: begin
        cmd.cur_cap = 1'b1;
        state_next  = ST_OUT_RD;
      end
      ST_OUT_RD: begin
        cmd.out_rd = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (sts.out_last) begin
            cmd.finish = 1'b1;
            state_next = ST_IDLE;
          end else begin
            cmd.out_rd = 1'b1;
          end
        end
      end
      ST_REJECT: begin
        if (sts.out_free) begin
          cmd.rej_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### sv/lzwccd_dp.sv
// Datapath: byte store, entry tables, recent-entry ring and output register.
`timescale 1ns / 1ps
`default_nettype none
`include "lzw_cached_code_decoder_unit_defines.svh"
module lzwccd_dp #(
  parameter int unsigned DICT_ENTRIES    = 4096,
  parameter int unsigned CACHE_SLOTS     = 16,
  parameter int unsigned STORE_BYTES     = 65536,
  parameter int unsigned MAX_ENTRY_BYTES = 64,
  parameter int unsigned CODE_BITS       = 12,
  parameter int unsigned SLOT_BITS       = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  lzwccd_pkg::cmd_t  cmd,
  output lzwccd_pkg::sts_t  sts,
  input  logic              in_first,
  input  logic              in_from_cache,
  input  logic [11:0]       in_code,
  lzwccd_out_if.source      out_ch
);
  import lzwccd_pkg::*;

  localparam int unsigned IDX_W  = $clog2(DICT_ENTRIES);
  localparam int unsigned NE_W   = $clog2(DICT_ENTRIES + 1);
  localparam int unsigned SA_W   = $clog2(STORE_BYTES);
  localparam int unsigned FILL_W = $clog2(STORE_BYTES + 1);
  localparam int unsigned SL_W   = $clog2(CACHE_SLOTS);
  localparam int unsigned CNT_W  = $clog2(CACHE_SLOTS + 1);
  localparam int unsigned CW     = (NE_W > CODE_W) ? NE_W : CODE_W;
  localparam logic [CODE_W-1:0] CODE_MASK = (12'(1) << CODE_BITS) - 12'd1;

  // storage
  logic [BYTE_W-1:0] store_mem [STORE_BYTES];
  logic [SA_W-1:0]   est_mem   [DICT_ENTRIES];
  logic [LEN_W-1:0]  elen_mem  [DICT_ENTRIES];
  logic [IDX_W-1:0]  ring_mem  [CACHE_SLOTS];

  // message state
  logic [NE_W-1:0]    ne;
  logic [FILL_W-1:0]  fill;
  logic [SL_W-1:0]    wpos;
  logic [CNT_W-1:0]   count;
  logic [IDX_W-1:0]   prev_code;
  logic               prev_valid;

  // per-request working registers
  logic [SLOT_BITS-1:0] slot_r;
  logic [CW-1:0]        cur;
  logic [SA_W-1:0]      pstart, cstart, w_addr;
  logic [LEN_W-1:0]     plen, clen, idx;
  logic [BYTE_W-1:0]    fbyte;
  logic                 w_vld;
  logic [IDX_W-1:0]     v;
  logic [CNT_W-1:0]     si;
  logic [SL_W-1:0]      c_idx, p, pend_p;
  logic                 c_vld, pend_vld;

  // read registers
  logic [BYTE_W-1:0]    st_q, st_lo;
  logic                 st_base;
  logic [SA_W-1:0]      est_q;
  logic [LEN_W-1:0]     elen_q;
  logic [7:0]           ent_lo;
  logic                 ent_base;
  logic [IDX_W-1:0]     ring_q;

  // output register
  logic                 out_vld, last_r, err_r;
  logic [BYTE_W-1:0]    out_byte_r;

  logic [BYTE_W-1:0]    st_byte;
  logic [SA_W-1:0]      ent_start;
  logic [LEN_W-1:0]     ent_len;
  logic [8:0]           slot9, wpos9, cnt9;
  logic [CW-1:0]        ne_c;
  logic                 kwk, hit, issue;
  logic [SL_W-1:0]      si_lo, q, wpos_inc;
  logic [FILL_W:0]      fill_need;
  logic                 st_re, ring_re, ent_re;
  logic [SA_W-1:0]      st_ra;
  logic [SL_W-1:0]      ring_ra;
  logic [IDX_W-1:0]     ent_ra;

  // base entries live in logic: entry i is the single byte i
  assign st_byte   = st_base ? st_lo : st_q;
  assign ent_start = ent_base ? SA_W'(ent_lo) : est_q;
  assign ent_len   = ent_base ? LEN_W'(1) : elen_q;

  assign slot9     = 9'(slot_r);
  assign wpos9     = 9'(wpos);
  assign cnt9      = 9'(count);
  assign ne_c      = CW'(ne);
  assign kwk       = (cur == ne_c);
  assign hit       = c_vld && (ring_q == v);
  assign issue     = cmd.srch && !hit && (si < count);
  assign si_lo     = si[SL_W-1:0];
  assign q         = (p == SL_W'(CACHE_SLOTS - 1)) ? '0 : p + SL_W'(1);
  assign wpos_inc  = (wpos == SL_W'(CACHE_SLOTS - 1)) ? '0 : wpos + SL_W'(1);
  assign fill_need = (FILL_W+1)'(fill) + (FILL_W+1)'(ent_len) + (FILL_W+1)'(1);

  always_comb begin
    sts            = '0;
    sts.from_cache = in_from_cache;
    sts.slot_bad   = (slot9 >= 9'(CACHE_SLOTS)) || ((slot9 != wpos9) && (slot9 >= cnt9));
    sts.slot_wpos  = (slot9 == wpos9);
    sts.cur_bad    = (cur > ne_c) || (cur >= CW'(DICT_ENTRIES)) || (kwk && !prev_valid);
    sts.do_add     = prev_valid && (ne < NE_W'(DICT_ENTRIES));
    sts.add_bad    = (ent_len >= LEN_W'(MAX_ENTRY_BYTES)) ||
                     (fill_need > (FILL_W+1)'(STORE_BYTES));
    sts.copy_last  = (idx + LEN_W'(1) == plen);
    sts.hit        = hit;
    sts.miss       = !hit && !(si < count);
    sts.rot_end    = (q == wpos);
    sts.out_free   = !out_vld || out_ch.ready;
    sts.out_last   = (idx == clen);
  end

  // read port selection
  always_comb begin
    st_re = 1'b1;
    st_ra = '0;
    if (cmd.first_rd) st_ra = kwk ? pstart : ent_start;
    else if (cmd.copy) st_ra = pstart + SA_W'(idx);
    else if (cmd.out_rd) st_ra = cstart + SA_W'(idx);
    else st_re = 1'b0;

    ring_re = 1'b1;
    ring_ra = '0;
    if (cmd.slot && !sts.slot_wpos) ring_ra = SL_W'(slot_r);
    else if (issue) ring_ra = si_lo;
    else if (cmd.rot && !sts.rot_end) ring_ra = q;
    else ring_re = 1'b0;

    ent_re = cmd.ent_rd_prev || cmd.ent_rd_cur;
    ent_ra = cmd.ent_rd_prev ? prev_code : cur[IDX_W-1:0];
  end

  // byte store
  always_ff @(posedge clk) begin
    if (st_re) begin
      st_q    <= store_mem[st_ra];
      st_base <= (st_ra < SA_W'(BASE_ENTRIES));
      st_lo   <= st_ra[7:0];
    end
    if (w_vld) store_mem[w_addr] <= st_byte;
    else if (cmd.add) store_mem[SA_W'(fill) + SA_W'(plen)] <= fbyte;
  end

  // entry tables
  always_ff @(posedge clk) begin
    if (ent_re) begin
      est_q    <= est_mem[ent_ra];
      elen_q   <= elen_mem[ent_ra];
      ent_base <= (ent_ra < IDX_W'(BASE_ENTRIES));
      ent_lo   <= ent_ra[7:0];
    end
    if (cmd.add) begin
      est_mem[ne[IDX_W-1:0]]  <= SA_W'(fill);
      elen_mem[ne[IDX_W-1:0]] <= plen + LEN_W'(1);
    end
  end

  // recent-entry ring
  always_ff @(posedge clk) begin
    if (ring_re) ring_q <= ring_mem[ring_ra];
    if (cmd.srch && sts.miss) ring_mem[wpos] <= v;
    else if (cmd.rot && pend_vld) ring_mem[pend_p] <= ring_q;
    else if (cmd.rot_fin) ring_mem[p] <= v;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      ne         <= NE_W'(BASE_ENTRIES);
      fill       <= FILL_W'(BASE_ENTRIES);
      wpos       <= '0;
      count      <= '0;
      prev_code  <= '0;
      prev_valid <= 1'b0;
      out_vld    <= 1'b0;
      c_vld      <= 1'b0;
      pend_vld   <= 1'b0;
      w_vld      <= 1'b0;
    end else begin
      if (cmd.accept && in_first) begin
        ne         <= NE_W'(BASE_ENTRIES);
        fill       <= FILL_W'(BASE_ENTRIES);
        wpos       <= '0;
        count      <= '0;
        prev_code  <= '0;
        prev_valid <= 1'b0;
      end
      if (cmd.add) begin
        ne   <= ne + NE_W'(1);
        fill <= fill + FILL_W'(plen) + FILL_W'(1);
      end
      // miss: insert at the write position, evicting the oldest
      if (cmd.srch && sts.miss) begin
        wpos <= wpos_inc;
        if (count < CNT_W'(CACHE_SLOTS)) count <= count + CNT_W'(1);
      end
      if (cmd.finish) begin
        prev_code  <= cur[IDX_W-1:0];
        prev_valid <= 1'b1;
      end
      w_vld <= cmd.copy;
      if (cmd.touch_cur || cmd.add) c_vld <= 1'b0;
      else if (cmd.srch) c_vld <= issue && (si_lo != wpos);
      if (cmd.rot) pend_vld <= !sts.rot_end;
      else pend_vld <= 1'b0;
      if (cmd.out_load || cmd.rej_load) out_vld <= 1'b1;
      else if (out_ch.ready) out_vld <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      slot_r <= in_code[SLOT_BITS-1:0];
      cur    <= CW'(in_code & CODE_MASK);
    end
    if (cmd.slot && sts.slot_wpos) cur <= ne_c;
    if (cmd.slot_cap) cur <= CW'(ring_q);
    if (cmd.prev_cap) begin
      pstart <= ent_start;
      plen   <= ent_len;
    end
    if (cmd.first_cap) begin
      fbyte <= st_byte;
      idx   <= '0;
    end
    if (cmd.copy) begin
      idx    <= idx + LEN_W'(1);
      w_addr <= SA_W'(fill) + SA_W'(idx);
    end
    if (cmd.cur_cap) begin
      cstart <= ent_start;
      clen   <= (ent_len > LEN_W'(MAX_ENTRY_BYTES)) ? LEN_W'(MAX_ENTRY_BYTES) : ent_len;
      idx    <= '0;
    end
    if (cmd.out_rd) idx <= idx + LEN_W'(1);
    if (cmd.touch_cur) begin
      v  <= cur[IDX_W-1:0];
      si <= '0;
    end else if (cmd.add) begin
      v  <= ne[IDX_W-1:0];
      si <= '0;
    end else if (issue) begin
      si    <= si + CNT_W'(1);
      c_idx <= si_lo;
    end
    if (cmd.srch && hit) p <= c_idx;
    else if (cmd.rot && !sts.rot_end) begin
      pend_p <= p;
      p      <= q;
    end
    if (cmd.out_load) begin
      out_byte_r <= st_byte;
      last_r     <= sts.out_last;
      err_r      <= 1'b0;
    end else if (cmd.rej_load) begin
      out_byte_r <= '0;
      last_r     <= 1'b1;
      err_r      <= 1'b1;
    end
  end

  assign out_ch.valid    = out_vld;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.last     = last_r;
  assign out_ch.error    = err_r;

  `LZWCCD_ASSERT(a_count_bound, (cnt9 <= 9'(CACHE_SLOTS)), "ring count above slot count")
  `LZWCCD_ASSERT(a_ne_bound, (ne <= NE_W'(DICT_ENTRIES)), "next entry beyond dictionary")
  `LZWCCD_ASSERT(a_fill_bound, (fill <= FILL_W'(STORE_BYTES)), "store fill beyond store")
  `LZWCCD_ASSERT(a_one_write, (!(w_vld && cmd.add)), "copy write collides with entry add")
  `LZWCCD_ASSERT(a_reject_out, (cmd.rej_load |=> (out_vld && err_r && last_r)), "reject not shown")

endmodule
`default_nettype wire

### sv/lzw_cached_code_decoder_unit.sv
// Top level of the cached-code LZW decoder: controller plus datapath.
//
//   channel   dir  handshake     payload
//   code_in   in   valid/ready   first_of_message, from_cache, code[11:0]
//   byte_out  out  valid/ready   out_byte[7:0], last, error
//
// One code request is handled at a time; code_in is ready only between requests.
// Each code searches and rotates the ring, twice when an entry is added, copies the
// previous entry into the byte store when adding, then reads out one byte at a time.
// A rejected code gives one byte with last and error set.
// rst is synchronous; it restores the 256 base entries at once, no clearing pass.
// byte_out stalls hold the output register; code_in may be taken while it waits.
`timescale 1ns / 1ps
`default_nettype none
module lzw_cached_code_decoder_unit #(
  parameter int unsigned DICT_ENTRIES    = 4096,
  parameter int unsigned CACHE_SLOTS     = 16,
  parameter int unsigned STORE_BYTES     = 65536,
  parameter int unsigned MAX_ENTRY_BYTES = 64,
  parameter int unsigned CODE_BITS       = 12,
  parameter int unsigned SLOT_BITS       = 4
) (
  input logic          clk,
  input logic          rst,
  lzwccd_in_if.sink    code_in,
  lzwccd_out_if.source byte_out
);
  import lzwccd_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign code_in.ready = in_ready;

  lzwccd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (code_in.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lzwccd_dp #(
    .DICT_ENTRIES    (DICT_ENTRIES),
    .CACHE_SLOTS     (CACHE_SLOTS),
    .STORE_BYTES     (STORE_BYTES),
    .MAX_ENTRY_BYTES (MAX_ENTRY_BYTES),
    .CODE_BITS       (CODE_BITS),
    .SLOT_BITS       (SLOT_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .in_first      (code_in.first_of_message),
    .in_from_cache (code_in.from_cache),
    .in_code       (code_in.code),
    .out_ch        (byte_out)
  );

endmodule
`default_nettype wire

### bench/testbench.sv
// Self-checking bench for the cached-code LZW decoder unit.
`timescale 1ns / 1ps
`default_nettype none
module testbench;

  localparam int DICT_N   = 4096;
  localparam int SLOTS_N  = 16;
  localparam int STORE_N  = 65536;
  localparam int MAXLEN   = 64;
  localparam int BASE_N   = lzwccd_pkg::BASE_ENTRIES;
  localparam int WD_LIMIT = 5000;

  typedef struct {
    bit          fom;
    bit          fc;
    logic [11:0] code;
    int          nres;
  } code_req_t;

  typedef struct {
    logic [7:0] out_byte;
    logic       last;
    logic       error;
  } dec_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lzwccd_in_if  cin();
  lzwccd_out_if cout();

  lzw_cached_code_decoder_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .code_in  (cin),
    .byte_out (cout)
  );

  always #5 clk = ~clk;

  // Decoder state copy, advanced as codes are generated (same order as accepted).
  logic [7:0] dec_bytes [STORE_N];
  int         ent_start [DICT_N];
  int         ent_len   [DICT_N];
  int         next_ent;
  int         fill;
  int         ring [SLOTS_N];
  int         wpos;
  int         rcnt;
  int         prev;
  bit         prev_ok;

  code_req_t  pend_reqs [$];
  dec_byte_t  exp_bytes [$];
  int         n_items;
  int         n_accepted;
  int         res_due;
  int         res_got;
  int         fails;
  int         quiet_cycles;
  bit         hold_for_drain;
  bit         taken;
  bit         gen_done;

  function automatic void clear_msg();
    next_ent = BASE_N;
    fill     = BASE_N;
    wpos     = 0;
    rcnt     = 0;
    prev     = 0;
    prev_ok  = 1'b0;
  endfunction

  function automatic void ring_touch(int v);
    int hit;
    int p;
    int q;
    int tmp;
    hit = -1;
    for (int i = 0; i < rcnt && i < SLOTS_N; i++) begin
      if (i != wpos && ring[i] == v && hit < 0) hit = i;
    end
    if (hit >= 0) begin
      // move the hit to newest, shifting the younger ones down
      tmp = ring[hit];
      p   = hit;
      for (int g = 0; g < SLOTS_N; g++) begin
        q = (p + 1) % SLOTS_N;
        if (q == wpos) break;
        ring[p] = ring[q];
        p = q;
      end
      ring[p] = tmp;
    end else begin
      ring[wpos] = v;
      wpos = (wpos + 1) % SLOTS_N;
      if (rcnt < SLOTS_N) rcnt++;
    end
  endfunction

  function automatic int reject_code();
    dec_byte_t r;
    r.out_byte = '0;
    r.last     = 1'b1;
    r.error    = 1'b1;
    exp_bytes.push_back(r);
    return 1;
  endfunction

  // Decode one code into exp_bytes; returns the number of bytes produced.
  function automatic int decode_code(bit fom, bit fc, logic [11:0] cd);
    int        cur;
    int        slot;
    int        plen;
    int        nlen;
    bit        kwk;
    logic [7:0] first;
    dec_byte_t r;
    if (fom) clear_msg();
    if (fc) begin
      slot = cd[3:0];
      if (slot == wpos) cur = next_ent;
      else if (slot < rcnt) cur = ring[slot];
      else return reject_code();
    end else begin
      cur = cd;
    end
    if (cur > next_ent || cur >= DICT_N) return reject_code();
    kwk = (cur == next_ent);
    if (kwk && !prev_ok) return reject_code();
    if (prev_ok && next_ent < DICT_N) begin
      plen = ent_len[prev];
      nlen = plen + 1;
      if (nlen > MAXLEN) return reject_code();
      if (fill + nlen > STORE_N) return reject_code();
      first = kwk ? dec_bytes[ent_start[prev]] : dec_bytes[ent_start[cur]];
      for (int i = 0; i < plen; i++) dec_bytes[fill + i] = dec_bytes[ent_start[prev] + i];
      dec_bytes[fill + plen] = first;
      ent_start[next_ent] = fill;
      ent_len[next_ent]   = nlen;
      ring_touch(next_ent);
      next_ent++;
      fill += nlen;
    end
    ring_touch(cur);
    for (int i = 0; i < ent_len[cur]; i++) begin
      r.out_byte = dec_bytes[ent_start[cur] + i];
      r.last     = (i + 1 == ent_len[cur]);
      r.error    = 1'b0;
      exp_bytes.push_back(r);
    end
    prev    = cur;
    prev_ok = 1'b1;
    return ent_len[cur];
  endfunction

  function automatic void add_req(bit fom, bit fc, int cd);
    code_req_t q;
    q.fom  = fom;
    q.fc   = fc;
    q.code = cd[11:0];
    q.nres = decode_code(fom, fc, q.code);
    pend_reqs.push_back(q);
    n_items++;
  endfunction

  // Idle rates follow the accepted count: receiver-heavy, then sender-heavy, then none.
  function automatic int send_idle();
    if (n_accepted < 85) return 13;
    if (n_accepted < 170) return 66;
    return 0;
  endfunction

  function automatic int recv_idle();
    if (n_accepted < 85) return 66;
    if (n_accepted < 170) return 13;
    return 0;
  endfunction

  // Request driver: accept at posedge, offer at negedge.
  always @(posedge clk) begin
    if (!rst && cin.valid && cin.ready) begin
      res_due <= res_due + pend_reqs[0].nres;
      void'(pend_reqs.pop_front());
      n_accepted <= n_accepted + 1;
      taken <= 1'b1;
    end else begin
      taken <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      cin.valid <= 1'b0;
    end else if (cin.valid && !taken) begin
      cin.valid <= 1'b1;
    end else if (pend_reqs.size() > 0 && !(hold_for_drain && res_got != res_due)
                 && $urandom_range(0, 99) >= send_idle()) begin
      cin.valid            <= 1'b1;
      cin.first_of_message <= pend_reqs[0].fom;
      cin.from_cache       <= pend_reqs[0].fc;
      cin.code             <= pend_reqs[0].code;
    end else begin
      cin.valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    cout.ready <= !rst && ($urandom_range(0, 99) >= recv_idle());
  end

  // Byte monitor.
  always @(posedge clk) begin
    dec_byte_t e;
    if (!rst && cout.valid && cout.ready) begin
      res_got <= res_got + 1;
      if (exp_bytes.size() == 0) begin
        $error("unexpected byte %0h last %0b error %0b", cout.out_byte, cout.last, cout.error);
        fails++;
      end else begin
        e = exp_bytes.pop_front();
        if (cout.out_byte !== e.out_byte) begin
          $error("out_byte expected %0h actual %0h", e.out_byte, cout.out_byte);
          fails++;
        end
        if (cout.last !== e.last) begin
          $error("last expected %0b actual %0b", e.last, cout.last);
          fails++;
        end
        if (cout.error !== e.error) begin
          $error("error expected %0b actual %0b", e.error, cout.error);
          fails++;
        end
      end
    end
  end

  // Watchdog on cycles with no request or byte moving.
  always @(posedge clk) begin
    if (rst || (cin.valid && cin.ready) || (cout.valid && cout.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WD_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int r;
    int e63;
    cin.valid            = 1'b0;
    cin.first_of_message = 1'b0;
    cin.from_cache       = 1'b0;
    cin.code             = '0;
    cout.ready           = 1'b0;
    n_items = 0; n_accepted = 0; res_due = 0; res_got = 0; fails = 0;
    quiet_cycles = 0; hold_for_drain = 0; taken = 0; gen_done = 0;
    for (int i = 0; i < STORE_N; i++) dec_bytes[i] = (i < BASE_N) ? i[7:0] : 8'h00;
    for (int i = 0; i < DICT_N; i++) begin
      ent_start[i] = (i < BASE_N) ? i : 0;
      ent_len[i]   = (i < BASE_N) ? 1 : 0;
    end
    for (int i = 0; i < SLOTS_N; i++) ring[i] = 0;
    clear_msg();

    // Directed: KwKwK with no previous code, extremes, bad slots and indexes.
    add_req(1, 1, 12'h000);
    add_req(0, 0, 12'hfff);
    add_req(0, 1, 12'h00f);
    add_req(0, 0, 12'h000);
    add_req(0, 0, 12'h0ff);
    add_req(0, 0, 256);
    add_req(0, 0, next_ent);
    add_req(0, 1, wpos);
    add_req(0, 1, 12'h000);
    add_req(0, 1, 12'h001);
    add_req(0, 1, 12'hff2);
    add_req(0, 0, next_ent + 1);
    add_req(0, 1, 12'h00f);
    add_req(1, 0, 12'h041);
    add_req(0, 0, 12'h042);
    add_req(0, 1, 12'h003);
    add_req(1, 1, 12'hff0);
    add_req(0, 0, 12'h080);

    // Random, mostly well-formed codes against the current dictionary.
    for (int n = 0; n < 150; n++) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        add_req(1, $urandom_range(0, 1), $urandom_range(0, 4095));
      end else if (r < 50) begin
        case ($urandom_range(0, 2))
          0: add_req(0, 0, $urandom_range(0, 255));
          1: add_req(0, 0, next_ent);
          default: add_req(0, 0, $urandom_range((next_ent > 264) ? next_ent - 8 : 256,
                                                next_ent));
        endcase
      end else if (r < 88) begin
        add_req(0, 1, ($urandom_range(0, 15) << 4) | $urandom_range(0, (rcnt > 0) ? rcnt : 0));
      end else begin
        add_req(0, $urandom_range(0, 1), $urandom_range(0, 4095));
      end
    end

    // Grow one chain to 63 bytes, then to the longest entry, then an overlong KwKwK.
    add_req(1, 0, 12'h0a5);
    for (int i = 0; i < 62; i++) add_req(0, 0, next_ent);
    e63 = next_ent - 1;
    add_req(0, 0, e63);
    add_req(0, 0, next_ent);
    add_req(0, 0, next_ent);
    add_req(0, 1, wpos);

    for (int i = 0; i < 10; i++) add_req(0, $urandom_range(0, 1), $urandom_range(0, 4095));
    gen_done = 1;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    wait (n_accepted == 60);
    hold_for_drain = 1;
    wait (res_got == res_due);
    @(posedge clk);
    hold_for_drain = 0;
    wait (gen_done && n_accepted == n_items && exp_bytes.size() == 0);
    repeat (200) @(posedge clk);
    if (fails == 0 && exp_bytes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

### filelist.f
+incdir+sv
sv/lzwccd_pkg.sv
sv/lzwccd_in_if.sv
sv/lzwccd_out_if.sv
sv/lzwccd_ctrl.sv
sv/lzwccd_dp.sv
sv/lzw_cached_code_decoder_unit.sv
bench/testbench.sv
